/* hdl/btp_pkg.sv */
`timescale 1ns / 1ps

package btp_pkg;

    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE        = 2'd2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 11'd4;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 13'd4;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 13'd4096;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic PHASE_FIRST  = 1'b0;
    localparam logic PHASE_SECOND = 1'b1;

    typedef struct packed {
        logic nw;
        logic no;
        logic ne;
        logic we;
        logic me;
        logic ea;
        logic sw;
        logic so;
        logic se;
    } t_window;

    typedef struct packed {
        logic pixel_out;
        logic deleted;
    } t_verdict;

endpackage

/* hdl/btp_in_if.sv */
`timescale 1ns / 1ps

interface btp_in_if;
    logic valid;
    logic ready;
    logic command;
    logic pixel_in;

    modport source (output valid, output command, output pixel_in, input ready);
    modport sink (input valid, input command, input pixel_in, output ready);
endinterface

/* hdl/btp_out_if.sv */
`timescale 1ns / 1ps

interface btp_out_if;
    logic valid;
    logic ready;
    logic pixel_out;
    logic deleted;
    logic end_of_frame;
    logic frame_changed;

    modport source (
        output valid, output pixel_out, output deleted, output end_of_frame,
        output frame_changed, input ready
    );
    modport sink (
        input valid, input pixel_out, input deleted, input end_of_frame,
        input frame_changed, output ready
    );
endinterface

/* hdl/btp_cfg_if.sv */
`timescale 1ns / 1ps

interface btp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [btp_pkg::CFG_IDX_W-1:0]   index;
    logic [btp_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/binary_image_thinning_pass_core.sv */
`timescale 1ns / 1ps

// One Zhang-Suen thinning sub-pass over a binary raster stream.
// Input channel i_in: one pixel per transaction, raster order; command=1 marks
// a flush item (pixel taken as 0). After each frame send width+1 flush items.
// Output channel o_out: thinned pixel one row and one column behind the input;
// the first width+1 items of a frame produce no output. end_of_frame marks the
// last pixel, frame_changed is a sticky flag of deletions in the frame.
// Config channel i_cfg: index 0 width, 1 height, 2 phase; always ready. Write
// only while the block is idle.
// Throughput: one item per cycle while o_out does not stall. The accepting
// edge registers the item and its row store read in the input stage; the
// window test result is then registered in the output register and written back.
// Reset: a clearing pass zeroes the row store while i_in is not
// ready. A stall on o_out holds the output register and the window stage; the
// input stays ready while the window stage can advance into a free or
// draining output register.

module binary_image_thinning_pass_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    btp_in_if.sink      i_in,
    btp_out_if.source   o_out,
    btp_cfg_if.sink     i_cfg
);

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int WB = ($clog2(MAX_WIDTH + 1) > btp_pkg::WIDTH_W) ?
                        $clog2(MAX_WIDTH + 1) : btp_pkg::WIDTH_W;
    localparam int HB = btp_pkg::HEIGHT_W;

    logic [btp_pkg::WIDTH_W-1:0] r_image_width;
    logic [HB-1:0]               r_image_height;
    logic                        r_phase;

    logic [1:0] mem [MAX_WIDTH];
    logic [1:0] r_rdata;

    logic          r_clr_done;
    logic [CB-1:0] r_clr_addr;

    logic [CB-1:0] r_col, n_col;
    logic [HB-1:0] r_row, n_row;

    logic          r_s1_valid;
    logic [CB-1:0] r_s1_col;
    logic          r_s1_x;
    logic          r_s1_emit;
    logic          r_s1_eof;
    logic          r_s1_border;

    logic [5:0] r_win;
    logic       r_any_del;

    logic r_out_valid;
    logic r_out_pixel;
    logic r_out_deleted;
    logic r_out_eof;
    logic r_out_changed;

    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;
    logic          accept;
    logic          s1_fire;
    logic          wrap;
    logic [CB-1:0] c_now;
    logic [HB-1:0] row_now;
    logic [WB-1:0] c_inc;
    logic          x_now;
    logic          emit_now;
    logic          eof_now;
    logic          border_now;

    logic [2:0]        prev_col;
    logic [2:0]        old_col;
    logic [2:0]        cur_col;
    btp_pkg::t_window  win;
    btp_pkg::t_verdict verdict;

    always_comb begin
        if (r_image_width < btp_pkg::WIDTH_MIN) begin
            w_eff = WB'(btp_pkg::WIDTH_MIN);
        end else if (WB'(r_image_width) > WB'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(r_image_width);
        end
        if (r_image_height < btp_pkg::HEIGHT_MIN) begin
            h_eff = btp_pkg::HEIGHT_MIN;
        end else if (r_image_height > btp_pkg::HEIGHT_MAX) begin
            h_eff = btp_pkg::HEIGHT_MAX;
        end else begin
            h_eff = r_image_height;
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= btp_pkg::WIDTH_RESET;
            r_image_height <= btp_pkg::HEIGHT_RESET;
            r_phase        <= btp_pkg::PHASE_FIRST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                btp_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg.data[btp_pkg::WIDTH_W-1:0];
                btp_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg.data[HB-1:0];
                btp_pkg::CFG_PHASE:        r_phase        <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Input stage: position, framing and row store read
    assign s1_fire = r_s1_valid && (!r_s1_emit || !r_out_valid || o_out.ready);
    assign i_in.ready = r_clr_done && (!r_s1_valid || s1_fire);
    assign accept = i_in.valid && i_in.ready;

    always_comb begin
        wrap       = WB'(r_col) >= w_eff;
        c_now      = wrap ? '0 : r_col;
        row_now    = wrap ? r_row + HB'(1) : r_row;
        x_now      = (i_in.command == btp_pkg::CMD_FLUSH) ? 1'b0 : i_in.pixel_in;
        emit_now   = (row_now >= HB'(2)) || ((row_now == HB'(1)) && (c_now != '0));
        eof_now    = row_now >= (h_eff + HB'(1));
        border_now = (c_now == '0) || (c_now == CB'(1)) || (row_now == HB'(1)) ||
                     (row_now >= h_eff);
        c_inc      = WB'(c_now) + WB'(1);
        if (eof_now) begin
            n_col = '0;
            n_row = '0;
        end else if (c_inc >= w_eff) begin
            n_col = '0;
            n_row = row_now + HB'(1);
        end else begin
            n_col = c_inc[CB-1:0];
            n_row = row_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col    <= c_now;
            r_s1_x      <= x_now;
            r_s1_emit   <= emit_now;
            r_s1_eof    <= eof_now;
            r_s1_border <= border_now;
        end
    end

    // Row store: bit 0 row above, bit 1 two rows above
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (s1_fire && (r_s1_col == c_now)) begin
                r_rdata <= {r_rdata[0], r_s1_x};
            end else begin
                r_rdata <= mem[c_now];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_clr_done) begin
            mem[r_clr_addr] <= 2'b00;
        end else if (s1_fire) begin
            mem[r_s1_col] <= {r_rdata[0], r_s1_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_done <= 1'b0;
            r_clr_addr <= '0;
        end else if (!r_clr_done) begin
            r_clr_addr <= r_clr_addr + CB'(1);
            if (r_clr_addr == CB'(MAX_WIDTH - 1)) begin
                r_clr_done <= 1'b1;
            end
        end
    end

    // Window stage
    assign prev_col = r_win[2:0];
    assign old_col  = r_win[5:3];
    assign cur_col  = {r_s1_x, r_rdata[0], r_rdata[1]};

    assign win.nw = old_col[0];
    assign win.we = old_col[1];
    assign win.sw = old_col[2];
    assign win.no = prev_col[0];
    assign win.me = prev_col[1];
    assign win.so = prev_col[2];
    assign win.ne = cur_col[0];
    assign win.ea = cur_col[1];
    assign win.se = cur_col[2];

    btp_judge u_judge (
        .i_win     (win),
        .i_phase   (r_phase),
        .i_border  (r_s1_border),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r_any_del   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_fire) begin
                r_win <= {prev_col, cur_col};
                if (r_s1_eof) begin
                    r_any_del <= 1'b0;
                end else if (r_s1_emit) begin
                    r_any_del <= r_any_del | verdict.deleted;
                end
            end
            if (s1_fire && r_s1_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_emit) begin
            r_out_pixel   <= verdict.pixel_out;
            r_out_deleted <= verdict.deleted;
            r_out_eof     <= r_s1_eof;
            r_out_changed <= r_any_del | verdict.deleted;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.pixel_out     = r_out_pixel;
    assign o_out.deleted       = r_out_deleted;
    assign o_out.end_of_frame  = r_out_eof;
    assign o_out.frame_changed = r_out_changed;

endmodule

/* hdl/btp_judge.sv */
`timescale 1ns / 1ps

module btp_judge (
    input  btp_pkg::t_window  i_win,
    input  logic              i_phase,
    input  logic              i_border,
    output btp_pkg::t_verdict o_verdict
);

    logic [7:0] ring;
    logic [3:0] trans_cnt;
    logic [3:0] set_cnt;
    logic       m1;
    logic       m2;
    logic       del;

    assign ring = {i_win.nw, i_win.we, i_win.sw, i_win.so,
                   i_win.se, i_win.ea, i_win.ne, i_win.no};

    always_comb begin
        trans_cnt = '0;
        set_cnt   = '0;
        for (int i = 0; i < 8; i++) begin
            trans_cnt = trans_cnt + 4'(!ring[i] && ring[(i + 1) % 8]);
            set_cnt   = set_cnt + 4'(ring[i]);
        end
    end

    always_comb begin
        unique case (i_phase)
            btp_pkg::PHASE_FIRST: begin
                m1 = i_win.no & i_win.ea & i_win.so;
                m2 = i_win.ea & i_win.so & i_win.we;
            end
            btp_pkg::PHASE_SECOND: begin
                m1 = i_win.no & i_win.ea & i_win.we;
                m2 = i_win.no & i_win.so & i_win.we;
            end
            default: begin
                m1 = 1'b0;
                m2 = 1'b0;
            end
        endcase
    end

    assign del = !i_border && i_win.me && (trans_cnt == 4'd1) &&
                 (set_cnt >= 4'd2) && (set_cnt <= 4'd6) && !m1 && !m2;

    assign o_verdict.pixel_out = del ? 1'b0 : i_win.me;
    assign o_verdict.deleted   = del;

endmodule

/* tb/binary_image_thinning_pass_core_tb.sv */
`timescale 1ns / 1ps

module binary_image_thinning_pass_core_tb;

    localparam int LINE_MAX      = 1024;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 100;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [btp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic pixel_out;
        logic deleted;
        logic end_of_frame;
        logic frame_changed;
    } t_thin_pixel;

    logic i_clk;
    logic i_rst_n;

    btp_in_if  in_ch();
    btp_out_if out_ch();
    btp_cfg_if cfg_ch();

    binary_image_thinning_pass_core #(
        .MAX_WIDTH (LINE_MAX)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_thin_pixel pending_pixels[$];

    logic [1:0]                   line_hist [LINE_MAX];
    logic [5:0]                   win_cols;
    int unsigned                  frame_col;
    int unsigned                  frame_row;
    logic                         sticky_del;
    logic [btp_pkg::WIDTH_W-1:0]  cfg_width;
    logic [btp_pkg::HEIGHT_W-1:0] cfg_height;
    logic                         cfg_phase;

    int unsigned items_sent;
    int unsigned bad_results;
    int unsigned quiet_cycles;
    bit          tx_idle_on;
    bit          rx_idle_on;
    bit          hold_req;
    int unsigned hold_len;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic int unsigned used_width();
        if (cfg_width < btp_pkg::WIDTH_MIN) return btp_pkg::WIDTH_MIN;
        if (cfg_width > LINE_MAX) return LINE_MAX;
        return cfg_width;
    endfunction

    function automatic int unsigned used_height();
        if (cfg_height < btp_pkg::HEIGHT_MIN) return btp_pkg::HEIGHT_MIN;
        if (cfg_height > btp_pkg::HEIGHT_MAX) return btp_pkg::HEIGHT_MAX;
        return cfg_height;
    endfunction

    task automatic thin_reset();
        for (int i = 0; i < LINE_MAX; i++) line_hist[i] = 2'b00;
        win_cols   = '0;
        frame_col  = 0;
        frame_row  = 0;
        sticky_del = 1'b0;
        cfg_width  = btp_pkg::WIDTH_RESET;
        cfg_height = btp_pkg::HEIGHT_RESET;
        cfg_phase  = btp_pkg::PHASE_FIRST;
    endtask

    task automatic thin_config(input logic [btp_pkg::CFG_IDX_W-1:0] idx,
                               input logic [btp_pkg::CFG_DAT_W-1:0] dat);
        case (idx)
            btp_pkg::CFG_IMAGE_WIDTH: begin
                cfg_width = dat[btp_pkg::WIDTH_W-1:0];
            end
            btp_pkg::CFG_IMAGE_HEIGHT: begin
                cfg_height = dat[btp_pkg::HEIGHT_W-1:0];
            end
            btp_pkg::CFG_PHASE: begin
                cfg_phase = dat[0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic thin_predict(input logic cmd, input logic pix);
        int unsigned w, h, r, c, cr, cc, rises, ones;
        logic x, above, above2, border, del, eof, m1, m2;
        logic [2:0] cur, prev, old;
        logic [7:0] ring;
        btp_pkg::t_window nb;
        t_thin_pixel res;
        w = used_width();
        h = used_height();
        if (frame_col >= w) begin
            frame_col = 0;
            frame_row++;
        end
        r = frame_row;
        c = frame_col;
        x = (cmd == btp_pkg::CMD_FLUSH) ? 1'b0 : pix;
        {above2, above} = line_hist[c % LINE_MAX];
        cur = {x, above, above2};
        line_hist[c % LINE_MAX] = {above, x};
        prev = win_cols[2:0];
        old  = win_cols[5:3];
        nb.nw = old[0];  nb.we = old[1];  nb.sw = old[2];
        nb.no = prev[0]; nb.me = prev[1]; nb.so = prev[2];
        nb.ne = cur[0];  nb.ea = cur[1];  nb.se = cur[2];
        eof = (r >= h + 1);
        if (r >= 2 || (r == 1 && c >= 1)) begin
            if (c == 0) begin
                cr = r - 2;
                cc = w - 1;
            end else begin
                cr = r - 1;
                cc = c - 1;
            end
            border = (cr == 0) || (cr >= h - 1) || (cc == 0) || (cc >= w - 1);
            // ring runs clockwise from north
            ring = {nb.nw, nb.we, nb.sw, nb.so, nb.se, nb.ea, nb.ne, nb.no};
            rises = 0;
            ones  = 0;
            for (int i = 0; i < 8; i++) begin
                if (!ring[i] && ring[(i + 1) % 8]) rises++;
                if (ring[i]) ones++;
            end
            if (cfg_phase == btp_pkg::PHASE_FIRST) begin
                m1 = nb.no & nb.ea & nb.so;
                m2 = nb.ea & nb.so & nb.we;
            end else begin
                m1 = nb.no & nb.ea & nb.we;
                m2 = nb.no & nb.so & nb.we;
            end
            del = !border && nb.me && rises == 1 && ones >= 2 && ones <= 6 && !m1 && !m2;
            if (del) sticky_del = 1'b1;
            res.pixel_out     = del ? 1'b0 : nb.me;
            res.deleted       = del;
            res.end_of_frame  = eof;
            res.frame_changed = sticky_del;
            pending_pixels.insert(pending_pixels.size(), res);
        end
        win_cols = {prev, cur};
        if (eof) begin
            frame_col  = 0;
            frame_row  = 0;
            sticky_del = 1'b0;
        end else begin
            frame_col = c + 1;
            if (frame_col >= w) begin
                frame_col = 0;
                frame_row = r + 1;
            end
        end
    endtask

    task automatic send_item(input logic cmd, input logic pix);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.command  <= cmd;
        in_ch.pixel_in <= pix;
        @(posedge i_clk);
        while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1)) @(posedge i_clk);
        thin_predict(cmd, pix);
        items_sent++;
    endtask

    task automatic cfg_write(input logic [btp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [btp_pkg::CFG_DAT_W-1:0] dat);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= dat;
        @(posedge i_clk);
        while (!(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) @(posedge i_clk);
        thin_config(idx, dat);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic finish_frame();
        while (frame_row != 0 || frame_col != 0) begin
            send_item(btp_pkg::CMD_FLUSH, 1'($urandom_range(0, 1)));
        end
    endtask

    // 4x4 frame; img and flush_mask are raster order from the msb
    task automatic send_pattern(input logic [15:0] img, input logic [15:0] flush_mask,
                                input logic pad_cmd);
        for (int i = 0; i < 16; i++) begin
            send_item(flush_mask[15-i] ? btp_pkg::CMD_FLUSH : btp_pkg::CMD_PIXEL, img[15-i]);
        end
        for (int i = 0; i < 5; i++) send_item(pad_cmd, 1'b1);
    endtask

    // a dense rectangle over a sparse background, then the padding
    task automatic send_frame(input int unsigned w, input int unsigned h, input bit noisy);
        int unsigned r0, r1, c0, c1, bg;
        logic cmd, pix;
        r0 = $urandom_range(0, h - 1);
        r1 = $urandom_range(r0, h - 1);
        c0 = $urandom_range(0, w - 1);
        c1 = $urandom_range(c0, w - 1);
        bg = $urandom_range(0, 40);
        for (int unsigned r = 0; r < h; r++) begin
            for (int unsigned c = 0; c < w; c++) begin
                if (r >= r0 && r <= r1 && c >= c0 && c <= c1) pix = ($urandom_range(0, 9) != 0);
                else pix = ($urandom_range(0, 99) < bg);
                cmd = (noisy && $urandom_range(0, 15) == 0) ? btp_pkg::CMD_FLUSH :
                                                              btp_pkg::CMD_PIXEL;
                send_item(cmd, pix);
            end
        end
        for (int unsigned i = 0; i <= w; i++) begin
            cmd = (noisy && $urandom_range(0, 7) == 0) ? btp_pkg::CMD_PIXEL :
                                                         btp_pkg::CMD_FLUSH;
            send_item(cmd, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_phase_select();
        cfg_write(btp_pkg::CFG_IMAGE_WIDTH, 13'd4);
        cfg_write(btp_pkg::CFG_IMAGE_HEIGHT, 13'd4);
        cfg_write(btp_pkg::CFG_PHASE, {12'd0, btp_pkg::PHASE_FIRST});
        send_pattern(16'h6760, 16'h0000, btp_pkg::CMD_FLUSH);
        wait_idle();
        cfg_write(btp_pkg::CFG_PHASE, {12'hFFF, btp_pkg::PHASE_SECOND});
        send_pattern(16'h6760, 16'h0000, btp_pkg::CMD_FLUSH);
        wait_idle();
    endtask

    task automatic test_flush_and_padding();
        send_pattern(16'hFFFF, 16'h0660, btp_pkg::CMD_PIXEL);
        wait_idle();
        send_pattern(16'h0000, 16'hF00F, btp_pkg::CMD_FLUSH);
        wait_idle();
    endtask

    task automatic test_clamped_registers();
        cfg_write(btp_pkg::CFG_IMAGE_WIDTH, 13'h1800);
        cfg_write(btp_pkg::CFG_IMAGE_HEIGHT, 13'h0000);
        cfg_write(CFG_SPARE, 13'h1FFF);
        send_pattern(16'h7EE7, 16'h0000, btp_pkg::CMD_FLUSH);
        wait_idle();
    endtask

    task automatic test_midframe_resize();
        cfg_write(btp_pkg::CFG_IMAGE_WIDTH, 13'd6);
        cfg_write(btp_pkg::CFG_IMAGE_HEIGHT, 13'd5);
        for (int i = 0; i < 17; i++) send_item(btp_pkg::CMD_PIXEL, 1'($urandom_range(0, 1)));
        wait_idle();
        cfg_write(btp_pkg::CFG_IMAGE_WIDTH, 13'd4);
        cfg_write(btp_pkg::CFG_IMAGE_HEIGHT, 13'd3);
        finish_frame();
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        cfg_write(btp_pkg::CFG_IMAGE_WIDTH, 13'd8);
        cfg_write(btp_pkg::CFG_IMAGE_HEIGHT, 13'd8);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_len   = HOLD_CYCLES;
        hold_req   = 1'b1;
        send_frame(8, 8, 1'b0);
        wait_idle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int unsigned w, h, start;
        logic ph;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            w  = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16) : $urandom_range(4, 8);
            h  = $urandom_range(4, 9);
            ph = ($urandom_range(0, 1) != 0) ? btp_pkg::PHASE_SECOND : btp_pkg::PHASE_FIRST;
            cfg_write(btp_pkg::CFG_IMAGE_WIDTH, {2'($urandom_range(0, 3)), 11'(w)});
            cfg_write(btp_pkg::CFG_IMAGE_HEIGHT, 13'(h));
            cfg_write(btp_pkg::CFG_PHASE, {12'($urandom_range(0, 4095)), ph});
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            send_frame(w, h, ($urandom_range(0, 4) == 0));
            wait_idle();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_extreme_sizes();
        logic cmd;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        cfg_write(btp_pkg::CFG_IMAGE_WIDTH, 13'h07FF);
        cfg_write(btp_pkg::CFG_IMAGE_HEIGHT, 13'd4);
        for (int i = 0; i < LINE_MAX + 3; i++) begin
            send_item(btp_pkg::CMD_PIXEL, 1'($urandom_range(0, 1)));
        end
        wait_idle();
        cfg_write(btp_pkg::CFG_IMAGE_WIDTH, 13'd4);
        finish_frame();
        wait_idle();
        cfg_write(btp_pkg::CFG_IMAGE_WIDTH, 13'h1804);
        cfg_write(btp_pkg::CFG_IMAGE_HEIGHT, 13'h1FFF);
        cfg_write(btp_pkg::CFG_PHASE, {12'd0, btp_pkg::PHASE_FIRST});
        for (int i = 0; i < 24; i++) begin
            cmd = ($urandom_range(0, 15) == 0) ? btp_pkg::CMD_FLUSH : btp_pkg::CMD_PIXEL;
            send_item(cmd, 1'($urandom_range(0, 1)));
        end
        wait_idle();
        cfg_write(btp_pkg::CFG_IMAGE_HEIGHT, 13'd4);
        finish_frame();
        wait_idle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin : result_sink
        int unsigned gap;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                gap = rx_idle_on ? $urandom_range(0, 9) : 0;
                if (gap != 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_thin_pixel want, got;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.pixel_out     = out_ch.pixel_out;
            got.deleted       = out_ch.deleted;
            got.end_of_frame  = out_ch.end_of_frame;
            got.frame_changed = out_ch.frame_changed;
            if (pending_pixels.size() == 0) begin
                bad_results++;
                if (bad_results <= 10) begin
                    $display("%0t: unexpected transaction pix=%0b del=%0b eof=%0b chg=%0b",
                             $realtime, got.pixel_out, got.deleted, got.end_of_frame,
                             got.frame_changed);
                end
            end else begin
                want = pending_pixels.pop_front();
                if (got.pixel_out !== want.pixel_out || got.deleted !== want.deleted ||
                    got.end_of_frame !== want.end_of_frame ||
                    got.frame_changed !== want.frame_changed) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display({"%0t: mismatch exp pix=%0b del=%0b eof=%0b chg=%0b, ",
                                  "got pix=%0b del=%0b eof=%0b chg=%0b"},
                                 $realtime, want.pixel_out, want.deleted, want.end_of_frame,
                                 want.frame_changed, got.pixel_out, got.deleted,
                                 got.end_of_frame, got.frame_changed);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.command  <= btp_pkg::CMD_PIXEL;
        in_ch.pixel_in <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= btp_pkg::CFG_IMAGE_WIDTH;
        cfg_ch.data    <= '0;
        quiet_cycles   = 0;
        items_sent     = 0;
        bad_results    = 0;
        hold_req       = 1'b0;
        hold_len       = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        thin_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_phase_select();
        test_flush_and_padding();
        test_clamped_registers();
        test_midframe_resize();
        test_output_backpressure();
        test_random_frames();
        test_extreme_sizes();

        wait_idle();
        if (bad_results == 0 && pending_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
